// File: rtl/core/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Types and codes shared by the two-stack string store blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

    // operation codes on the input beat
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_CLOSE = 3'd1;
    localparam logic [2:0] OP_POP   = 3'd2;
    localparam logic [2:0] OP_PEEK  = 3'd3;
    localparam logic [2:0] OP_DROP  = 3'd4;
    localparam logic [2:0] OP_CLEAR = 3'd5;
    localparam logic [2:0] OP_QUERY = 3'd6;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_BADCH = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic       stack_select;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
        logic [1:0] status;
        logic       empty_flag;
    } t_out_item;

    typedef enum logic [2:0] {
        K_PUSH,
        K_CLOSE,
        K_POP,
        K_PEEK,
        K_DROP,
        K_CLEAR,
        K_QUERY,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic       sel;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_SCAN,
        S_SWAIT,
        S_SDONE,
        S_DROP,
        S_ERD,
        S_EWAIT
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/tss_front.sv
// ----------------------------------------------------------------------------
// tss_front
// Input side: takes beats while the queue has room and decodes the operation.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_front
    import tss_pkg::*;
(
    input  wire      i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  wire      i_q_full,
    output logic     o_q_push,
    output t_cmd     o_q_cmd
);

    t_kind w_kind;

    always_comb begin
        case (i_in_data.operation)
            OP_PUSH:  w_kind = K_PUSH;
            OP_CLOSE: w_kind = K_CLOSE;
            OP_POP:   w_kind = K_POP;
            OP_PEEK:  w_kind = K_PEEK;
            OP_DROP:  w_kind = K_DROP;
            OP_CLEAR: w_kind = K_CLEAR;
            OP_QUERY: w_kind = K_QUERY;
            default:  w_kind = K_NOP;
        endcase
    end

    assign o_in_stall   = i_q_full;
    assign o_q_push     = i_in_valid && !i_q_full;
    assign o_q_cmd.kind = w_kind;
    assign o_q_cmd.sel  = i_in_data.stack_select;
    assign o_q_cmd.data = i_in_data.data_byte;

endmodule

`default_nettype wire

// File: rtl/core/tss_queue.sv
// ----------------------------------------------------------------------------
// tss_queue
// Two-entry command queue between the decode front and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_queue
    import tss_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  wire  i_pop
);

    t_cmd       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

    assign o_full  = r_cnt[1];
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_ent[r_rp];

endmodule

`default_nettype wire

// File: rtl/core/tss_back.sv
// ----------------------------------------------------------------------------
// tss_back
// Sequencer: owns the byte store and both stack pointers, executes one
// command at a time and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_back
    import tss_pkg::*;
#(
    parameter int CAPACITY       = 256,
    parameter int MAX_STRING_LEN = 63
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int LW = $clog2(MAX_STRING_LEN + 1);

    localparam logic [PW-1:0] TOP2_RST = PW'(CAPACITY);
    localparam logic [AW-1:0] LAST_IDX = AW'(CAPACITY - 1);
    localparam logic [LW-1:0] MAXL     = LW'(MAX_STRING_LEN);

    logic [7:0] mem [CAPACITY];

    t_state    r_state, n_state;
    t_cmd      r_cmd,   n_cmd;
    // r_t2p1 holds the stack-two top plus one, so it never goes negative
    logic [PW-1:0] r_top1, n_top1;
    logic [PW-1:0] r_t2p1, n_t2p1;
    logic [LW-1:0] r_len1, n_len1;
    logic [LW-1:0] r_len2, n_len2;
    logic [AW-1:0] r_first, n_first;
    logic [LW-1:0] r_n, n_n;
    logic [LW-1:0] r_k, n_k;
    logic [7:0]    r_rd;
    logic          r_ov, n_ov;
    t_out_item     r_out, n_out;

    logic          w_we, w_re;
    logic [AW-1:0] w_wa, w_ra;
    logic [7:0]    w_wd;

    logic          sel;
    logic [LW-1:0] len_sel, len_oth;
    logic [PW-1:0] free_cells, need, t2_idx;
    logic          empty1, empty2, empty_sel;
    logic          can_close, out_free, scan_cont, k_last;
    logic [1:0]    push_status;
    logic [AW-1:0] top1_a, top2_a;

    assign sel        = r_cmd.sel;
    assign len_sel    = sel ? r_len2 : r_len1;
    assign len_oth    = sel ? r_len1 : r_len2;
    assign free_cells = r_t2p1 - r_top1;
    assign need       = (len_oth != '0) ? PW'(3) : PW'(2);
    assign t2_idx     = r_t2p1 - PW'(1);
    assign top1_a     = r_top1[AW-1:0];
    assign top2_a     = t2_idx[AW-1:0];
    assign empty1     = (r_top1 == '0) && (r_len1 == '0);
    assign empty2     = (r_t2p1 == TOP2_RST) && (r_len2 == '0);
    assign empty_sel  = sel ? empty2 : empty1;
    assign can_close  = (len_sel != '0) && (r_top1 < r_t2p1);
    assign out_free   = !r_ov || !i_out_stall;
    assign k_last     = r_k == (r_n - LW'(1));
    assign scan_cont  = (r_n < MAXL) && (sel ? (r_first != LAST_IDX) : (r_first != '0));

    always_comb begin
        if (r_cmd.data == 8'd0 || len_sel >= MAXL) begin
            push_status = ST_BADCH;
        end else if (free_cells < need) begin
            push_status = ST_FULL;
        end else begin
            push_status = ST_OK;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_cmd.kind == K_POP || r_cmd.kind == K_PEEK || r_cmd.kind == K_DROP) begin
                    n_state = S_CHECK;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (!empty_sel) begin
                    n_state = S_SCAN;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN:  n_state = scan_cont ? S_SWAIT : S_SDONE;
            S_SWAIT: n_state = (r_rd != 8'd0) ? S_SCAN : S_SDONE;
            S_SDONE: n_state = (r_cmd.kind == K_DROP) ? S_DROP : S_ERD;
            S_DROP: begin
                if (out_free) n_state = S_IDLE;
            end
            S_ERD:   n_state = S_EWAIT;
            S_EWAIT: begin
                if (out_free) n_state = k_last ? S_IDLE : S_ERD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd   = r_cmd;
        n_top1  = r_top1;
        n_t2p1  = r_t2p1;
        n_len1  = r_len1;
        n_len2  = r_len2;
        n_first = r_first;
        n_n     = r_n;
        n_k     = r_k;
        n_ov    = r_ov && i_out_stall;
        n_out   = r_out;
        w_we    = 1'b0;
        w_wa    = top1_a;
        w_wd    = 8'd0;
        w_re    = 1'b0;
        w_ra    = r_first;
        o_q_pop = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                end
            end
            S_EXEC: begin
                case (r_cmd.kind)
                    K_POP, K_PEEK, K_DROP: begin
                        // an open string is closed before it is read
                        if (can_close) begin
                            w_we = 1'b1;
                            w_wd = 8'd0;
                            if (sel) begin
                                w_wa   = top2_a;
                                n_t2p1 = t2_idx;
                                n_len2 = '0;
                            end else begin
                                w_wa   = top1_a;
                                n_top1 = r_top1 + PW'(1);
                                n_len1 = '0;
                            end
                        end
                    end
                    K_PUSH: begin
                        if (out_free) begin
                            n_ov  = 1'b1;
                            n_out = '{char_out: 8'd0, last: 1'b1, status: push_status,
                                      empty_flag: (push_status == ST_OK) ? 1'b0 : empty_sel};
                            if (push_status == ST_OK) begin
                                w_we = 1'b1;
                                w_wd = r_cmd.data;
                                if (sel) begin
                                    w_wa   = top2_a;
                                    n_t2p1 = t2_idx;
                                    n_len2 = r_len2 + LW'(1);
                                end else begin
                                    w_wa   = top1_a;
                                    n_top1 = r_top1 + PW'(1);
                                    n_len1 = r_len1 + LW'(1);
                                end
                            end
                        end
                    end
                    K_CLOSE: begin
                        if (out_free) begin
                            n_ov  = 1'b1;
                            n_out = '{char_out: 8'd0, last: 1'b1, status: ST_OK,
                                      empty_flag: can_close ? 1'b0 : empty_sel};
                            if (can_close) begin
                                w_we = 1'b1;
                                w_wd = 8'd0;
                                if (sel) begin
                                    w_wa   = top2_a;
                                    n_t2p1 = t2_idx;
                                    n_len2 = '0;
                                end else begin
                                    w_wa   = top1_a;
                                    n_top1 = r_top1 + PW'(1);
                                    n_len1 = '0;
                                end
                            end
                        end
                    end
                    K_CLEAR: begin
                        if (out_free) begin
                            n_ov   = 1'b1;
                            n_out  = '{char_out: 8'd0, last: 1'b1, status: ST_OK,
                                       empty_flag: 1'b1};
                            n_top1 = '0;
                            n_t2p1 = TOP2_RST;
                            n_len1 = '0;
                            n_len2 = '0;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            n_ov  = 1'b1;
                            n_out = '{char_out: 8'd0, last: 1'b1, status: ST_OK,
                                      empty_flag: empty_sel};
                        end
                    end
                endcase
            end
            S_CHECK: begin
                if (empty_sel) begin
                    if (out_free) begin
                        n_ov  = 1'b1;
                        n_out = '{char_out: 8'd0, last: 1'b1, status: ST_EMPTY,
                                  empty_flag: 1'b1};
                    end
                end else begin
                    // last character sits just inside the terminator
                    n_first = sel ? AW'(r_t2p1 + PW'(1)) : AW'(r_top1 - PW'(2));
                    n_n     = LW'(1);
                end
            end
            S_SCAN: begin
                if (scan_cont) begin
                    w_re = 1'b1;
                    w_ra = sel ? (r_first + AW'(1)) : (r_first - AW'(1));
                end
            end
            S_SWAIT: begin
                if (r_rd != 8'd0) begin
                    n_first = sel ? (r_first + AW'(1)) : (r_first - AW'(1));
                    n_n     = r_n + LW'(1);
                end
            end
            S_SDONE: begin
                n_k = '0;
                if (r_cmd.kind != K_PEEK) begin
                    if (sel) begin
                        n_t2p1 = PW'(r_first) + PW'(1);
                    end else begin
                        n_top1 = PW'(r_first);
                    end
                end
            end
            S_DROP: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = '{char_out: 8'd0, last: 1'b1, status: ST_OK,
                              empty_flag: empty_sel};
                end
            end
            S_ERD: begin
                w_re = 1'b1;
                w_ra = sel ? (r_first - AW'(r_k)) : (r_first + AW'(r_k));
            end
            S_EWAIT: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = '{char_out: r_rd, last: k_last, status: ST_OK,
                              empty_flag: empty_sel};
                    n_k   = r_k + LW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top1  <= '0;
            r_t2p1  <= TOP2_RST;
            r_len1  <= '0;
            r_len2  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top1  <= n_top1;
            r_t2p1  <= n_t2p1;
            r_len1  <= n_len1;
            r_len2  <= n_len2;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_first <= n_first;
        r_n     <= n_n;
        r_k     <= n_k;
        r_out   <= n_out;
    end

    // byte store, single port, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= mem[w_ra];
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: rtl/core/two_string_stacks_shared_buffer_core.sv
// Push, close, clear and query: the accepted command is registered, executed in the
// EXEC state, and its single result beat is registered. Pop, peek and drop scan the
// store one character at a time to find the string start; pop and peek then send one character per beat.
// The sequencer takes a new command from the queue only once the last one is done.
// Reset clears both stack pointers and open lengths; the byte store
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// two_string_stacks_shared_buffer_core
// Two stacks of zero-terminated strings in one byte store, decode front,
// command queue and store sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module two_string_stacks_shared_buffer_core
    import tss_pkg::*;
#(
    parameter int CAPACITY       = 256,
    parameter int MAX_STRING_LEN = 63
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_item o_out_data
);

    logic q_full, q_push, q_valid, q_pop;
    t_cmd q_in_cmd, q_out_cmd;

    tss_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    tss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    tss_back #(
        .CAPACITY       (CAPACITY),
        .MAX_STRING_LEN (MAX_STRING_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

// File: rtl/core/tss_checker.sv
// ----------------------------------------------------------------------------
// tss_checker
// Port-level assertions for the two-stack string store, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module tss_checker
    import tss_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input t_out_item o_out_data
);

    // held result beat stays put while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a failing status only ever comes as a single beat
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> o_out_data.last)
        else $error("error status on a non-final beat");

    a_err_nochar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ST_OK) |-> o_out_data.char_out == 8'd0)
        else $error("character returned with error status");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_EMPTY) |-> o_out_data.empty_flag)
        else $error("empty status without empty flag");

endmodule

bind two_string_stacks_shared_buffer_core tss_checker u_tss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
